### rtl/fas_pkg.sv
// Package for the fit allocation search core: shared constants, codes and
// the command and status structs between controller and datapath.
// No dependencies.
package fas_pkg;

  // Default sizing of the block table.
  localparam int NumBlocksDef = 8;
  localparam int SizeWidthDef = 32;

  // Fixed field widths.
  localparam int IdxW   = 3;
  localparam int CountW = 4;
  localparam int ModeW  = 2;

  // Block count after reset.
  localparam logic [CountW-1:0] CountReset = 4'd8;

  // Operation codes of an input beat.
  typedef enum logic {
    OpLoad  = 1'b0,
    OpQuery = 1'b1
  } op_e;

  // Fit modes; the remaining code is reserved and never finds a block.
  typedef enum logic [ModeW-1:0] {
    FitFirst = 2'd0,
    FitBest  = 2'd1,
    FitWorst = 2'd2
  } fit_mode_e;

  // Controller states.
  typedef enum logic [1:0] {
    StIdle,
    StScan,
    StDrain,
    StReport
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;    // write the table entry of the accepted beat
    logic start;   // capture the query and clear the search result
    logic issue;   // read the next table entry
    logic report;  // move the search result into the output register
  } fas_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic limit_zero;  // no entry is to be scanned
    logic scan_last;   // the entry being read is the last one
    logic out_busy;    // the output register holds a beat not yet taken
  } fas_status_t;

endpackage

### rtl/fas_if.sv
// Channel interfaces of the fit allocation search core: request, response
// and configuration write. Depends on fas_pkg.
interface fas_req_if
  import fas_pkg::*;
#(
  parameter int SizeWidth = SizeWidthDef
);
  logic                 valid;
  logic                 ready;
  logic                 operation;
  logic [IdxW-1:0]      entry_index;
  logic [SizeWidth-1:0] entry_size;
  logic                 entry_free;
  logic [SizeWidth-1:0] request_size;
  logic [ModeW-1:0]     fit_mode;

  modport source (
    output valid, operation, entry_index, entry_size, entry_free, request_size, fit_mode,
    input  ready
  );
  modport sink (
    input  valid, operation, entry_index, entry_size, entry_free, request_size, fit_mode,
    output ready
  );
endinterface

interface fas_rsp_if
  import fas_pkg::*;
();
  logic            valid;
  logic            ready;
  logic            found;
  logic [IdxW-1:0] block_index;

  modport source (output valid, found, block_index, input ready);
  modport sink (input valid, found, block_index, output ready);
endinterface

interface fas_cfg_if
  import fas_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [CountW-1:0] data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

### rtl/fas_ctrl.sv
// Controller of the fit allocation search core: accepts beats and sequences
// the table scan and the report. Depends on fas_pkg.
module fas_ctrl
  import fas_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        req_valid_i,
  input  logic        req_operation_i,
  output logic        req_ready_o,
  input  fas_status_t status_i,
  output fas_cmd_t    cmd_o
);

  state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands.
  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    req_ready_o = 1'b0;
    unique case (state_q)
      StIdle: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          if (req_operation_i == OpLoad) begin
            cmd_o.load = 1'b1;
          end else begin
            cmd_o.start = 1'b1;
            state_d     = status_i.limit_zero ? StReport : StScan;
          end
        end
      end
      StScan: begin
        cmd_o.issue = 1'b1;
        if (status_i.scan_last) begin
          state_d = StDrain;
        end
      end
      StDrain: begin
        // The last entry read is evaluated in this cycle.
        state_d = StReport;
      end
      StReport: begin
        if (!status_i.out_busy) begin
          cmd_o.report = 1'b1;
          state_d      = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

endmodule

### rtl/fas_datapath.sv
// Datapath of the fit allocation search core: block table, block count,
// scan address, fit selection and output register. Depends on fas_pkg.
module fas_datapath
  import fas_pkg::*;
#(
  parameter int NumBlocks = NumBlocksDef,
  parameter int SizeWidth = SizeWidthDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // Request payload
  input  logic [IdxW-1:0]      entry_index_i,
  input  logic [SizeWidth-1:0] entry_size_i,
  input  logic                 entry_free_i,
  input  logic [SizeWidth-1:0] request_size_i,
  input  logic [ModeW-1:0]     fit_mode_i,
  // Configuration write
  input  logic                 cfg_valid_i,
  input  logic [CountW-1:0]    cfg_data_i,
  // Response
  input  logic                 rsp_ready_i,
  output logic                 rsp_valid_o,
  output logic                 rsp_found_o,
  output logic [IdxW-1:0]      rsp_block_index_o,
  // Controller link
  input  fas_cmd_t             cmd_i,
  output fas_status_t          status_o
);

  localparam int AddrW = (NumBlocks > 1) ? $clog2(NumBlocks) : 1;
  localparam int CapW  = $clog2(NumBlocks + 1);
  localparam int LimW  = (CapW > CountW) ? CapW : CountW;

  // Table storage: sizes in a memory, free marks in flip-flops cleared by reset.
  logic [SizeWidth-1:0] size_mem [NumBlocks];
  logic [NumBlocks-1:0] free_q;

  logic [CountW-1:0]    count_q;
  logic [LimW-1:0]      limit_d, limit_q, count_ext, addr_q;
  logic [SizeWidth-1:0] req_size_q;
  logic [ModeW-1:0]     mode_q;

  logic                 rd_vld_q, rd_free_q;
  logic [SizeWidth-1:0] rd_size_q;
  logic [IdxW-1:0]      rd_idx_q;

  logic                 have_q;
  logic [IdxW-1:0]      pick_q;
  logic [SizeWidth-1:0] best_q;

  logic                 rsp_valid_q, rsp_found_q;
  logic [IdxW-1:0]      rsp_index_q;

  logic                 load_in_table, qualify, better, mode_valid;
  logic [AddrW-1:0]     waddr, raddr;

  // Block count register; the user must write it only while the core is idle, the block does not enforce this.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= CountReset;
    end else if (cfg_valid_i) begin
      count_q <= cfg_data_i;
    end
  end

  // Entries scanned: the block count saturated at the table depth.
  assign count_ext = LimW'(count_q);
  assign limit_d   = (count_ext > LimW'(NumBlocks)) ? LimW'(NumBlocks) : count_ext;

  assign load_in_table = (LimW'(entry_index_i) < LimW'(NumBlocks));
  assign waddr         = AddrW'(entry_index_i);
  assign raddr         = addr_q[AddrW-1:0];

  // Size memory: one write port for loads, one registered read port for the scan.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load && load_in_table) begin
      size_mem[waddr] <= entry_size_i;
    end
    if (cmd_i.issue) begin
      rd_size_q <= size_mem[raddr];
      rd_free_q <= free_q[raddr];
      rd_idx_q  <= IdxW'(addr_q);
    end
  end

  // Free marks.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      free_q <= '0;
    end else if (cmd_i.load && load_in_table) begin
      free_q[waddr] <= entry_free_i;
    end
  end

  // Query capture and scan address.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_q   <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      rd_vld_q <= cmd_i.issue;
      if (cmd_i.start) begin
        addr_q <= '0;
      end else if (cmd_i.issue) begin
        addr_q <= addr_q + LimW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      req_size_q <= request_size_i;
      mode_q     <= fit_mode_i;
      limit_q    <= limit_d;
    end
  end

  // Fit selection on the entry read in the previous cycle. First fit keeps
  // its first hit; best and worst fit replace only on a strict improvement,
  // so ties stay with the lowest index.
  assign mode_valid = (mode_q == FitFirst) || (mode_q == FitBest) || (mode_q == FitWorst);
  assign qualify    = rd_vld_q && rd_free_q && (rd_size_q >= req_size_q) && mode_valid;

  always_comb begin
    better = 1'b0;
    if (!have_q) begin
      better = 1'b1;
    end else if (mode_q == FitBest) begin
      better = (rd_size_q < best_q);
    end else if (mode_q == FitWorst) begin
      better = (rd_size_q > best_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_q <= 1'b0;
      pick_q <= '0;
    end else if (cmd_i.start) begin
      have_q <= 1'b0;
      pick_q <= '0;
    end else if (qualify && better) begin
      have_q <= 1'b1;
      pick_q <= rd_idx_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (qualify && better) begin
      best_q <= rd_size_q;
    end
  end

  // Output register; holds its beat until the sink takes it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if (cmd_i.report) begin
      rsp_valid_q <= 1'b1;
    end else if (rsp_ready_i) begin
      rsp_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.report) begin
      rsp_found_q <= have_q;
      rsp_index_q <= pick_q;
    end
  end

  assign rsp_valid_o       = rsp_valid_q;
  assign rsp_found_o       = rsp_found_q;
  assign rsp_block_index_o = rsp_index_q;

  // Status towards the controller.
  assign status_o.limit_zero = (limit_d == '0);
  assign status_o.scan_last  = (addr_q == (limit_q - LimW'(1)));
  assign status_o.out_busy   = rsp_valid_q && !rsp_ready_i;

endmodule

### rtl/fit_allocation_search_core.sv
// Top level of the fit allocation search core: first, best and worst fit
// search over a table of block sizes. Depends on fas_pkg, fas_if, fas_ctrl
// and fas_datapath.
//
//   Channel  Direction  Beat carries
//   req_i    in         load (index, size, free mark) or query (request size, mode)
//   rsp_o    out        found flag and block index, one per query
//   cfg_i    in         block count
//
// Loads may follow one another in every cycle while no query is under way.
// A query passes through capture, a scan of min(block_count, NumBlocks)
// table entries, read one at a time through the single read port of the
// size memory, then drain and report before the next beat can be accepted.
// A block count of zero skips the scan and the drain.
// Reset clears all free marks and sets the block count to eight; no sweep.
// A result waiting in the output register does not hold up loads; a query
// that finishes while it still waits is held until the sink takes it.
module fit_allocation_search_core
  import fas_pkg::*;
#(
  parameter int NumBlocks = NumBlocksDef,
  parameter int SizeWidth = SizeWidthDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  fas_req_if.sink   req_i,
  fas_rsp_if.source rsp_o,
  fas_cfg_if.sink   cfg_i
);

  fas_cmd_t    cmd;
  fas_status_t status;

  // Configuration writes are taken at once.
  assign cfg_i.ready = 1'b1;

  fas_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .req_valid_i     (req_i.valid),
    .req_operation_i (req_i.operation),
    .req_ready_o     (req_i.ready),
    .status_i        (status),
    .cmd_o           (cmd)
  );

  fas_datapath #(
    .NumBlocks (NumBlocks),
    .SizeWidth (SizeWidth)
  ) u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .entry_index_i     (req_i.entry_index),
    .entry_size_i      (req_i.entry_size),
    .entry_free_i      (req_i.entry_free),
    .request_size_i    (req_i.request_size),
    .fit_mode_i        (req_i.fit_mode),
    .cfg_valid_i       (cfg_i.valid),
    .cfg_data_i        (cfg_i.data),
    .rsp_ready_i       (rsp_o.ready),
    .rsp_valid_o       (rsp_o.valid),
    .rsp_found_o       (rsp_o.found),
    .rsp_block_index_o (rsp_o.block_index),
    .cmd_i             (cmd),
    .status_o          (status)
  );

endmodule

### rtl/fas_checker.sv
// Port checker of the fit allocation search core, attached by bind.
// Depends on fas_pkg and the top level fit_allocation_search_core.
module fas_checker
  import fas_pkg::*;
(
  input logic            clk_i,
  input logic            rst_ni,
  input logic            req_valid_i,
  input logic            req_ready_i,
  input logic            req_operation_i,
  input logic            rsp_valid_i,
  input logic            rsp_ready_i,
  input logic            rsp_found_i,
  input logic [IdxW-1:0] rsp_block_index_i
);

  // A response beat stays offered until it is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i)
    else $error("response beat withdrawn before it was taken");

  // A stalled response beat keeps its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> $stable(rsp_found_i) && $stable(rsp_block_index_i))
    else $error("stalled response payload changed");

  // A miss reports block index zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_found_i |-> rsp_block_index_i == '0)
    else $error("miss reported with a non-zero block index");

  // Once a query is accepted, no further beat is accepted in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i && (req_operation_i == OpQuery) |=> !req_ready_i)
    else $error("request accepted while a query scan is under way");

endmodule

bind fit_allocation_search_core fas_checker u_fas_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .req_valid_i       (req_i.valid),
  .req_ready_i       (req_i.ready),
  .req_operation_i   (req_i.operation),
  .rsp_valid_i       (rsp_o.valid),
  .rsp_ready_i       (rsp_o.ready),
  .rsp_found_i       (rsp_o.found),
  .rsp_block_index_i (rsp_o.block_index)
);
